[hw/rtl/gne_pkg.sv]
// Shared types, constants and codes of the grid neighbor expander.
package gne_pkg;

    localparam int COORD_W    = 6;
    localparam int SIZE_W     = 7;
    localparam int DIST_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int COORD_SPAN = 1 << COORD_W;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ROW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COL = 3'd3;

    localparam logic [SIZE_W-1:0]  RST_GRID_ROWS  = 7'd64;
    localparam logic [SIZE_W-1:0]  RST_GRID_COLS  = 7'd64;
    localparam logic [COORD_W-1:0] RST_TARGET_ROW = 6'd0;
    localparam logic [COORD_W-1:0] RST_TARGET_COL = 6'd0;

    localparam logic CMD_MARK   = 1'b0;
    localparam logic CMD_EXPAND = 1'b1;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_E = 2'd1,
        DIR_W = 2'd2,
        DIR_S = 2'd3
    } t_dir;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_CHECK = 2'd2,
        ST_EMIT  = 2'd3
    } t_state;

    typedef struct packed {
        logic [SIZE_W-1:0]  grid_rows;
        logic [SIZE_W-1:0]  grid_cols;
        logic [COORD_W-1:0] target_row;
        logic [COORD_W-1:0] target_col;
    } t_cfg;

    // Request to the neighbor unit: which neighbor of which cell.
    typedef struct packed {
        t_dir               dir;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_nbr_req;

    // Neighbor unit answer.
    typedef struct packed {
        logic               inbound;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [DIST_W-1:0]  distance;
        logic               at_goal;
    } t_nbr;

    // Blocked-map access from the sequencer.
    typedef struct packed {
        logic               wr_en;
        logic [COORD_W-1:0] wr_row;
        logic [COORD_W-1:0] wr_col;
        logic [COORD_W-1:0] rd_row;
        logic [COORD_W-1:0] rd_col;
    } t_map_req;

endpackage

[hw/rtl/gne_if.sv]
// Request and result channel interfaces of the grid neighbor expander.
interface gne_req_if;
    import gne_pkg::*;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;

    modport source (output valid, output cmd, output cell_row, output cell_col, input ready);
    modport sink   (input valid, input cmd, input cell_row, input cell_col, output ready);
endinterface

interface gne_rsp_if;
    import gne_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] succ_row;
    logic [COORD_W-1:0] succ_col;
    logic [DIST_W-1:0]  manhattan;
    logic               at_goal;
    logic               none_found;
    logic               last;

    modport source (output valid, output succ_row, output succ_col, output manhattan,
                    output at_goal, output none_found, output last, input ready);
    modport sink   (input valid, input succ_row, input succ_col, input manhattan,
                    input at_goal, input none_found, input last, output ready);
endinterface

[hw/rtl/gne_map.sv]
// Blocked-cell bitmap with clearing pass after reset.
module gne_map
    import gne_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_map_req i_req,
    output logic     o_blocked,
    output logic     o_clearing
);

    localparam int MAP_ROWS = (MAX_ROWS < COORD_SPAN) ? MAX_ROWS : COORD_SPAN;
    localparam int MAP_COLS = (MAX_COLS < COORD_SPAN) ? MAX_COLS : COORD_SPAN;
    localparam int RA_W     = $clog2(MAP_ROWS);
    localparam int CA_W     = $clog2(MAP_COLS);
    localparam int AW       = RA_W + CA_W;
    localparam int DEPTH    = 1 << AW;

    logic          r_mem [DEPTH];
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic          r_blocked;
    logic          wr_in_map;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // Drop marks that fall outside the stored map.
    assign wr_in_map = ({1'b0, i_req.wr_row} < SIZE_W'(MAP_ROWS))
                    && ({1'b0, i_req.wr_col} < SIZE_W'(MAP_COLS));
    assign wr_addr   = {i_req.wr_row[RA_W-1:0], i_req.wr_col[CA_W-1:0]};
    assign rd_addr   = {i_req.rd_row[RA_W-1:0], i_req.rd_col[CA_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_req.wr_en && wr_in_map) begin
            r_mem[wr_addr] <= 1'b1;
        end
        r_blocked <= r_mem[rd_addr];
    end

    assign o_blocked  = r_blocked;
    assign o_clearing = r_clearing;

endmodule

[hw/rtl/gne_nbr_unit.sv]
// Shared neighbor unit: offset, bounds check, Manhattan distance, goal compare.
module gne_nbr_unit
    import gne_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  t_cfg     i_cfg,
    input  t_nbr_req i_req,
    output t_nbr     o_nbr
);

    localparam int ROW_LIM = (MAX_ROWS < COORD_SPAN) ? MAX_ROWS : COORD_SPAN;
    localparam int COL_LIM = (MAX_COLS < COORD_SPAN) ? MAX_COLS : COORD_SPAN;

    logic [SIZE_W-1:0]  rows_eff;
    logic [SIZE_W-1:0]  cols_eff;
    logic [SIZE_W-1:0]  nr;
    logic [SIZE_W-1:0]  nc;
    logic               under;
    logic [COORD_W-1:0] dr;
    logic [COORD_W-1:0] dc;

    assign rows_eff = (i_cfg.grid_rows > SIZE_W'(ROW_LIM)) ? SIZE_W'(ROW_LIM) : i_cfg.grid_rows;
    assign cols_eff = (i_cfg.grid_cols > SIZE_W'(COL_LIM)) ? SIZE_W'(COL_LIM) : i_cfg.grid_cols;

    always_comb begin
        nr    = {1'b0, i_req.row};
        nc    = {1'b0, i_req.col};
        under = 1'b0;
        unique case (i_req.dir)
            DIR_N: begin
                under = (i_req.row == '0);
                nr    = {1'b0, i_req.row} - SIZE_W'(1);
            end
            DIR_E: begin
                nc    = {1'b0, i_req.col} + SIZE_W'(1);
            end
            DIR_W: begin
                under = (i_req.col == '0);
                nc    = {1'b0, i_req.col} - SIZE_W'(1);
            end
            DIR_S: begin
                nr    = {1'b0, i_req.row} + SIZE_W'(1);
            end
            default: begin
                under = 1'b1;
            end
        endcase
    end

    assign dr = (nr[COORD_W-1:0] > i_cfg.target_row) ? nr[COORD_W-1:0] - i_cfg.target_row
                                                      : i_cfg.target_row - nr[COORD_W-1:0];
    assign dc = (nc[COORD_W-1:0] > i_cfg.target_col) ? nc[COORD_W-1:0] - i_cfg.target_col
                                                      : i_cfg.target_col - nc[COORD_W-1:0];

    assign o_nbr.inbound  = !under && (nr < rows_eff) && (nc < cols_eff);
    assign o_nbr.row      = nr[COORD_W-1:0];
    assign o_nbr.col      = nc[COORD_W-1:0];
    assign o_nbr.distance = {1'b0, dr} + {1'b0, dc};
    assign o_nbr.at_goal  = (nr[COORD_W-1:0] == i_cfg.target_row)
                         && (nc[COORD_W-1:0] == i_cfg.target_col);

endmodule

[hw/rtl/gne_ctrl.sv]
// Sequencer: probes four neighbors, then emits results through an output register.
module gne_ctrl
    import gne_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    gne_req_if.sink     i_req,
    gne_rsp_if.source   o_rsp,
    input  logic        i_clearing,
    input  logic        i_blocked,
    input  t_nbr        i_nbr,
    output t_nbr_req    o_nbr_req,
    output t_map_req    o_map_req
);

    t_state             r_state, n_state;
    t_dir               r_dir, n_dir;
    logic [COORD_W-1:0] r_row, n_row;
    logic [COORD_W-1:0] r_col, n_col;
    logic [3:0]         r_mask, n_mask;

    logic               r_out_valid, n_out_valid;
    logic [COORD_W-1:0] r_out_row, n_out_row;
    logic [COORD_W-1:0] r_out_col, n_out_col;
    logic [DIST_W-1:0]  r_out_dist, n_out_dist;
    logic               r_out_goal, n_out_goal;
    logic               r_out_none, n_out_none;
    logic               r_out_last, n_out_last;

    logic               accept;
    logic               out_free;
    logic               higher;

    assign i_req.ready = (r_state == ST_IDLE) && !i_clearing;
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign o_nbr_req.dir = r_dir;
    assign o_nbr_req.row = r_row;
    assign o_nbr_req.col = r_col;

    assign o_map_req.wr_en  = accept && (i_req.cmd == CMD_MARK);
    assign o_map_req.wr_row = i_req.cell_row;
    assign o_map_req.wr_col = i_req.cell_col;
    assign o_map_req.rd_row = i_nbr.row;
    assign o_map_req.rd_col = i_nbr.col;

    // Any legal neighbor after the current one.
    always_comb begin
        unique case (r_dir)
            DIR_N:   higher = |r_mask[3:1];
            DIR_E:   higher = |r_mask[3:2];
            DIR_W:   higher = r_mask[3];
            DIR_S:   higher = 1'b0;
            default: higher = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_dir       = r_dir;
        n_row       = r_row;
        n_col       = r_col;
        n_mask      = r_mask;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_dist  = r_out_dist;
        n_out_goal  = r_out_goal;
        n_out_none  = r_out_none;
        n_out_last  = r_out_last;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_req.cmd == CMD_EXPAND)) begin
                    n_row   = i_req.cell_row;
                    n_col   = i_req.cell_col;
                    n_dir   = DIR_N;
                    n_mask  = '0;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_mask[r_dir] = i_nbr.inbound && !i_blocked;
                if (r_dir == DIR_S) begin
                    n_dir   = DIR_N;
                    n_state = ST_EMIT;
                end else begin
                    n_dir   = t_dir'(r_dir + 2'd1);
                    n_state = ST_READ;
                end
            end
            ST_EMIT: begin
                if (r_mask == '0) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_row   = '0;
                        n_out_col   = '0;
                        n_out_dist  = '0;
                        n_out_goal  = 1'b0;
                        n_out_none  = 1'b1;
                        n_out_last  = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else if (r_mask[r_dir]) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_row   = i_nbr.row;
                        n_out_col   = i_nbr.col;
                        n_out_dist  = i_nbr.distance;
                        n_out_goal  = i_nbr.at_goal;
                        n_out_none  = 1'b0;
                        n_out_last  = !higher;
                        n_dir       = t_dir'(r_dir + 2'd1);
                        if (!higher) begin
                            n_state = ST_IDLE;
                        end
                    end
                end else begin
                    n_dir = t_dir'(r_dir + 2'd1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dir      <= n_dir;
        r_row      <= n_row;
        r_col      <= n_col;
        r_mask     <= n_mask;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_dist <= n_out_dist;
        r_out_goal <= n_out_goal;
        r_out_none <= n_out_none;
        r_out_last <= n_out_last;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.succ_row   = r_out_row;
    assign o_rsp.succ_col   = r_out_col;
    assign o_rsp.manhattan  = r_out_dist;
    assign o_rsp.at_goal    = r_out_goal;
    assign o_rsp.none_found = r_out_none;
    assign o_rsp.last       = r_out_last;

endmodule

[hw/rtl/grid_neighbor_expander_top.sv]
// Top level of the grid neighbor expander: configuration registers and block wiring.
//
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    cmd, cell_row, cell_col
//  o_rsp     out  valid/ready    succ_row, succ_col, manhattan, at_goal, none_found, last
//  i_cfg_*   in   write enable   i_cfg_idx selects the register, i_cfg_data holds the value
//
// A mark request is written into the map as it is taken. An expand request steps through
// a read state and a check state for each of the four neighbors in turn, since the blocked
// map has a single, registered read port, then an emit state that steps through the
// neighbors in order and sends each legal one through the shared neighbor unit.
// After reset the map is swept clear, one entry a cycle, 4096 entries at the default size
// (rows, columns each rounded up to a power of two); requests wait, config writes go on.
// A stalled result holds in the output register and the sequencer waits on it.
module grid_neighbor_expander_top
    import gne_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gne_req_if.sink               i_req,
    gne_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    t_nbr_req nbr_req;
    t_nbr     nbr;
    t_map_req map_req;
    logic     map_blocked;
    logic     map_clearing;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_rows  <= RST_GRID_ROWS;
            r_cfg.grid_cols  <= RST_GRID_COLS;
            r_cfg.target_row <= RST_TARGET_ROW;
            r_cfg.target_col <= RST_TARGET_COL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_ROWS:  r_cfg.grid_rows  <= i_cfg_data;
                CFG_GRID_COLS:  r_cfg.grid_cols  <= i_cfg_data;
                CFG_TARGET_ROW: r_cfg.target_row <= i_cfg_data[COORD_W-1:0];
                CFG_TARGET_COL: r_cfg.target_col <= i_cfg_data[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer owns the request handshake and the output register.
    gne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_clearing (map_clearing),
        .i_blocked  (map_blocked),
        .i_nbr      (nbr),
        .o_nbr_req  (nbr_req),
        .o_map_req  (map_req)
    );

    // One neighbor per cycle: coordinates, bounds, distance and goal compare.
    gne_nbr_unit #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_nbr (
        .i_cfg (r_cfg),
        .i_req (nbr_req),
        .o_nbr (nbr)
    );

    // Blocked map: registered read, mark writes, clearing sweep after reset.
    gne_map #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (map_req),
        .o_blocked  (map_blocked),
        .o_clearing (map_clearing)
    );

endmodule

[hw/rtl/gne_checker.sv]
// Port-level checks of the grid neighbor expander and their bind.
module gne_checker
    import gne_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               i_req_ready,
    input logic               i_req_cmd,
    input logic               o_rsp_valid,
    input logic               o_rsp_ready,
    input logic [COORD_W-1:0] o_rsp_succ_row,
    input logic [COORD_W-1:0] o_rsp_succ_col,
    input logic [DIST_W-1:0]  o_rsp_manhattan,
    input logic               o_rsp_at_goal,
    input logic               o_rsp_none_found,
    input logic               o_rsp_last
);

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid && $stable(o_rsp_succ_row)
            && $stable(o_rsp_succ_col) && $stable(o_rsp_manhattan) && $stable(o_rsp_last))
        else $error("result changed while stalled");

    // An expand request closes the request side while it runs.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_cmd == CMD_EXPAND) |=> !i_req_ready)
        else $error("request taken during expand");

    // A none-found result is final and carries zero fields.
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp_none_found |-> o_rsp_last && !o_rsp_at_goal
            && (o_rsp_manhattan == '0) && (o_rsp_succ_row == '0) && (o_rsp_succ_col == '0))
        else $error("malformed none-found result");

    // Reaching the goal means zero distance.
    a_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp_at_goal |-> (o_rsp_manhattan == '0) && !o_rsp_none_found)
        else $error("goal flag with nonzero distance");

endmodule

bind grid_neighbor_expander_top gne_checker u_gne_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_req_cmd        (i_req.cmd),
    .o_rsp_valid      (o_rsp.valid),
    .o_rsp_ready      (o_rsp.ready),
    .o_rsp_succ_row   (o_rsp.succ_row),
    .o_rsp_succ_col   (o_rsp.succ_col),
    .o_rsp_manhattan  (o_rsp.manhattan),
    .o_rsp_at_goal    (o_rsp.at_goal),
    .o_rsp_none_found (o_rsp.none_found),
    .o_rsp_last       (o_rsp.last)
);

[dv/gne_tb_pkg.sv]
// Successor prediction and result scoreboard for the grid neighbor expander bench.
package gne_tb_pkg;
    import gne_pkg::*;

    // One result as it leaves the block.
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [DIST_W-1:0]  manhattan;
        logic               at_goal;
        logic               none_found;
        logic               last;
    } t_successor;

    class gne_scoreboard;
        localparam int PRINT_CAP = 200;

        bit                 blocked [COORD_SPAN][COORD_SPAN];
        logic [SIZE_W-1:0]  rows_reg;
        logic [SIZE_W-1:0]  cols_reg;
        logic [COORD_W-1:0] goal_row;
        logic [COORD_W-1:0] goal_col;
        t_successor         successor_q [$];
        int                 mismatches;
        int                 results_seen;

        function new();
            rows_reg     = RST_GRID_ROWS;
            cols_reg     = RST_GRID_COLS;
            goal_row     = RST_TARGET_ROW;
            goal_col     = RST_TARGET_COL;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GRID_ROWS:  rows_reg = data[SIZE_W-1:0];
                CFG_GRID_COLS:  cols_reg = data[SIZE_W-1:0];
                CFG_TARGET_ROW: goal_row = data[COORD_W-1:0];
                CFG_TARGET_COL: goal_col = data[COORD_W-1:0];
                default: ;
            endcase
        endfunction

        // Sizes above the map clamp to it; zero leaves no legal cell.
        function int rows_in_use();
            return (rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows_reg);
        endfunction

        function int cols_in_use();
            return (cols_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols_reg);
        endfunction

        function int abs_diff(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        function int pending();
            return successor_q.size();
        endfunction

        // Mark a cell, or expand it into the successors the block must send.
        function void note_request(logic cmd, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
            int         rows_used;
            int         cols_used;
            int         nr;
            int         nc;
            int         dr;
            int         dc;
            t_successor s;
            t_successor found [$];
            if (cmd == CMD_MARK) begin
                blocked[row][col] = 1'b1;
                return;
            end
            rows_used = rows_in_use();
            cols_used = cols_in_use();
            for (int k = 0; k < 4; k++) begin
                case (t_dir'(k))
                    DIR_N:   begin dr = -1; dc =  0; end
                    DIR_E:   begin dr =  0; dc =  1; end
                    DIR_W:   begin dr =  0; dc = -1; end
                    default: begin dr =  1; dc =  0; end
                endcase
                nr = int'(row) + dr;
                nc = int'(col) + dc;
                if (nr < 0 || nc < 0 || nr >= rows_used || nc >= cols_used) continue;
                if (blocked[nr][nc]) continue;
                s           = '0;
                s.row       = nr[COORD_W-1:0];
                s.col       = nc[COORD_W-1:0];
                s.manhattan = DIST_W'(abs_diff(nr, int'(goal_row)) + abs_diff(nc, int'(goal_col)));
                s.at_goal   = (nr == int'(goal_row)) && (nc == int'(goal_col));
                found.push_back(s);
            end
            if (found.size() == 0) begin
                s            = '0;
                s.none_found = 1'b1;
                s.last       = 1'b1;
            end else begin
                s      = found.pop_back();
                s.last = 1'b1;
            end
            found.push_back(s);
            foreach (found[i]) successor_q.push_back(found[i]);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP) $display("MISMATCH result %0d: %s", results_seen, msg);
        endtask

        task compare_field(string name, logic [DIST_W-1:0] seen, logic [DIST_W-1:0] want);
            if (seen !== want) report($sformatf("%s is %0h, expected %0h", name, seen, want));
        endtask

        task check_successor(t_successor got);
            t_successor want;
            results_seen++;
            if (successor_q.size() == 0) begin
                report($sformatf("nothing pending, got row %0d col %0d none_found %0b",
                                 got.row, got.col, got.none_found));
                return;
            end
            want = successor_q.pop_front();
            compare_field("succ_row",   DIST_W'(got.row),        DIST_W'(want.row));
            compare_field("succ_col",   DIST_W'(got.col),        DIST_W'(want.col));
            compare_field("manhattan",  got.manhattan,           want.manhattan);
            compare_field("at_goal",    DIST_W'(got.at_goal),    DIST_W'(want.at_goal));
            compare_field("none_found", DIST_W'(got.none_found), DIST_W'(want.none_found));
            compare_field("last",       DIST_W'(got.last),       DIST_W'(want.last));
        endtask
    endclass

endpackage

[dv/tb_top.sv]
// Top-level testbench of the grid neighbor expander: stimulus, handshake drivers and checks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gne_pkg::*;
    import gne_tb_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int MAX_GAP      = 11;
    // Quiet time that lets a running expand or mark finish before a register write.
    localparam int QUIET_CYCLES = 20;
    // Long enough for the output register and the sequencer to fill and push back on requests.
    localparam int HOLD_CYCLES  = 300;
    // Must outlast the quiet map clear after reset and the long result hold.
    localparam int STALL_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 260;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    gne_req_if req_ch ();
    gne_rsp_if rsp_ch ();

    gne_scoreboard board = new();
    t_successor    seen;

    // Per-phase switches: when set, that side never idles.
    bit tx_busy;
    bit rx_busy;
    // Bumped by the stimulus to ask the result side for one long hold-off.
    int holds_asked;

    grid_neighbor_expander_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Drivers. Everything changes on the falling edge; the block and the
    // monitors sample on the rising edge.
    // ------------------------------------------------------------------

    // Write all four registers back to back. Call only with the block idle.
    task automatic write_config(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols,
                                input logic [COORD_W-1:0] trow, input logic [COORD_W-1:0] tcol);
        cfg_we   = 1'b1;
        cfg_idx  = CFG_GRID_ROWS;
        cfg_data = rows;
        @(negedge i_clk);
        cfg_idx  = CFG_GRID_COLS;
        cfg_data = cols;
        @(negedge i_clk);
        cfg_idx  = CFG_TARGET_ROW;
        cfg_data = CFG_DATA_W'(trow);
        @(negedge i_clk);
        cfg_idx  = CFG_TARGET_COL;
        cfg_data = CFG_DATA_W'(tcol);
        @(negedge i_clk);
        cfg_we   = 1'b0;
        board.write_reg(CFG_GRID_ROWS, rows);
        board.write_reg(CFG_GRID_COLS, cols);
        board.write_reg(CFG_TARGET_ROW, CFG_DATA_W'(trow));
        board.write_reg(CFG_TARGET_COL, CFG_DATA_W'(tcol));
    endtask

    // Offer one request and hold it until the block takes it. Enter and leave on a falling edge.
    // With no gap drawn, valid simply stays high into the next request.
    task automatic send_request(input logic cmd, input logic [COORD_W-1:0] row,
                                input logic [COORD_W-1:0] col);
        int gap;
        gap = tx_busy ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.cmd      = cmd;
        req_ch.cell_row = row;
        req_ch.cell_col = col;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted successor has come back.
    task automatic drain();
        req_ch.valid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    // Drain, then give trailing marks time to land before touching the registers.
    task automatic settle();
        drain();
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    // Sizes: zero, one, all ones, the map size, just past it, else random from 2 to 12 or to 64.
    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SIZE_W'(1);
            2:       return '1;
            3:       return SIZE_W'(DEF_MAX_ROWS);
            4:       return SIZE_W'(DEF_MAX_ROWS + 1);
            5, 6:    return SIZE_W'($urandom_range(2, 12));
            default: return SIZE_W'($urandom_range(2, 64));
        endcase
    endfunction

    // Targets lean toward the small grids so goal hits are common.
    function automatic logic [COORD_W-1:0] pick_target();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return COORD_W'($urandom_range(0, 11));
            default: return COORD_W'($urandom_range(0, COORD_SPAN - 1));
        endcase
    endfunction

    // Mostly expands. Cells land mostly inside the grid in use, some next to the
    // goal, and the rest anywhere on the coordinate range.
    task automatic random_request();
        int                 rows_used;
        int                 cols_used;
        int                 pick;
        logic               cmd;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        rows_used = board.rows_in_use();
        cols_used = board.cols_in_use();
        cmd  = ($urandom_range(0, 9) < 7) ? CMD_EXPAND : CMD_MARK;
        pick = $urandom_range(0, 9);
        if (pick < 2 || rows_used == 0 || cols_used == 0) begin
            row = COORD_W'($urandom_range(0, COORD_SPAN - 1));
            col = COORD_W'($urandom_range(0, COORD_SPAN - 1));
        end else if (pick < 4) begin
            // Wraps past the coordinate edges to the opposite side.
            row = COORD_W'(board.goal_row + $urandom_range(0, 2) - 1);
            col = COORD_W'(board.goal_col + $urandom_range(0, 2) - 1);
        end else begin
            row = COORD_W'($urandom_range(0, rows_used - 1));
            col = COORD_W'($urandom_range(0, cols_used - 1));
        end
        send_request(cmd, row, col);
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready gaps, stretches with none, and one long
    // hold-off on request from the stimulus.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        int holds_done;
        holds_done    = 0;
        rsp_ch.ready  = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (holds_asked > holds_done) begin
                holds_done++;
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = rx_busy ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                rsp_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            rsp_ch.ready = 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Monitors: note each accepted request, check each accepted result.
    // A result never shares an edge with the request that causes it.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                board.note_request(req_ch.cmd, req_ch.cell_row, req_ch.cell_col);
            if (rsp_ch.valid && rsp_ch.ready) begin
                seen.row        = rsp_ch.succ_row;
                seen.col        = rsp_ch.succ_col;
                seen.manhattan  = rsp_ch.manhattan;
                seen.at_goal    = rsp_ch.at_goal;
                seen.none_found = rsp_ch.none_found;
                seen.last       = rsp_ch.last;
                board.check_successor(seen);
            end
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
                stalled = 0;
            else
                stalled++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int random_sent;
        int phase;
        int phase_len;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_GRID_ROWS;
        cfg_data        = '0;
        req_ch.valid    = 1'b0;
        req_ch.cmd      = CMD_MARK;
        req_ch.cell_row = '0;
        req_ch.cell_col = '0;
        tx_busy         = 1'b0;
        rx_busy         = 1'b0;
        holds_asked     = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: full 64 x 64 grid, goal at the origin. The block
        // clears its map first; requests simply wait on ready.
        send_request(CMD_EXPAND, 6'd0, 6'd0);       // corner: east and south only
        send_request(CMD_EXPAND, 6'd0, 6'd1);       // west neighbor is the goal
        send_request(CMD_EXPAND, 6'd63, 6'd63);     // far corner, largest distance
        send_request(CMD_EXPAND, 6'd63, 6'd0);
        send_request(CMD_EXPAND, 6'd0, 6'd63);
        // Wall in cell (5,5) on all four sides.
        send_request(CMD_MARK, 6'd4, 6'd5);
        send_request(CMD_MARK, 6'd5, 6'd6);
        send_request(CMD_MARK, 6'd5, 6'd4);
        send_request(CMD_MARK, 6'd6, 6'd5);
        send_request(CMD_EXPAND, 6'd5, 6'd5);       // every neighbor blocked
        send_request(CMD_EXPAND, 6'd4, 6'd5);       // a blocked cell still expands
        send_request(CMD_MARK, 6'd0, 6'd0);
        send_request(CMD_EXPAND, 6'd1, 6'd0);       // north neighbor now blocked
        send_request(CMD_EXPAND, 6'd42, 6'd21);     // alternating coordinate bits
        send_request(CMD_EXPAND, 6'd21, 6'd42);
        settle();

        // Zero rows: nothing is legal anywhere.
        write_config('0, '1, '1, '1);
        send_request(CMD_EXPAND, 6'd10, 6'd10);
        send_request(CMD_EXPAND, 6'd0, 6'd0);
        settle();

        // Rows past the map clamp to 64; a single column. Goal on the bottom row.
        write_config('1, SIZE_W'(1), 6'd63, 6'd0);
        send_request(CMD_EXPAND, 6'd62, 6'd0);      // south neighbor is the goal
        send_request(CMD_EXPAND, 6'd63, 6'd0);
        send_request(CMD_EXPAND, 6'd5, 6'd5);       // cell outside the grid in use
        settle();

        // One-cell grid, and the only cell is blocked.
        write_config(SIZE_W'(1), SIZE_W'(1), '0, '0);
        send_request(CMD_EXPAND, 6'd0, 6'd0);
        send_request(CMD_EXPAND, 6'd1, 6'd0);
        settle();

        // Random phases, each with fresh settings. The first runs the sender flat out
        // against one long result hold-off so the block backs up into its input.
        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            write_config(pick_size(), pick_size(), pick_target(), pick_target());
            tx_busy = (phase == 0) || ($urandom_range(0, 3) == 0);
            rx_busy = (phase != 0) && ($urandom_range(0, 3) == 0);
            if (phase == 0) holds_asked++;
            phase_len = $urandom_range(20, 40);
            repeat (phase_len) begin
                random_request();
                random_sent++;
                // Now and then stop and let the block run dry.
                if ($urandom_range(0, 29) == 0) drain();
            end
            settle();
            phase++;
        end

        if (board.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/gne_pkg.sv
hw/rtl/gne_if.sv
hw/rtl/gne_map.sv
hw/rtl/gne_nbr_unit.sv
hw/rtl/gne_ctrl.sv
hw/rtl/grid_neighbor_expander_top.sv
hw/rtl/gne_checker.sv
dv/gne_tb_pkg.sv
dv/tb_top.sv
